@@ sv/assert_macros.svh @@
// assertion macros shared by the cube root rtl
// expects clk_i and rst_ni in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ICRF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ICRF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`endif

@@ sv/icrf_pkg.sv @@
// types and constants for the integer cube root float pipeline
// no dependencies
`default_nettype none
package icrf_pkg;
  // positive binary32 without the sign bit
  typedef logic [30:0] flt_t;

  localparam flt_t SEED_A_MAG = 31'h3EF05D37;
  localparam flt_t SEED_B     = 31'h3F894131;
  localparam flt_t SEED_C     = 31'h3EC3335F;
  localparam flt_t THIRD      = 31'h3EAAAAAB;
  localparam flt_t TWO_THIRD  = 31'h3F2AAAAB;

  localparam logic [7:0] EXP_BIAS  = 8'd127;
  localparam logic [7:0] FRAC_BIAS = 8'd126;

  localparam int unsigned DIV_STEPS = 25;

  // data that rides alongside each request through the units
  typedef struct packed {
    logic       zero;
    logic [2:0] k;
    flt_t       tx;
    flt_t       r;
    flt_t       aux;
  } side_t;
endpackage
`default_nettype wire

@@ sv/integer_cube_root_float.sv @@
// top level: cube root of a 16-bit integer as a binary32 bit pattern
// uses icrf_pkg, icrf_fmul, icrf_fadd, icrf_newton, assert_macros.svh
//
//  channel  handshake          payload
//  request  valid_i / stall_o  operand_i   [15:0]
//  result   valid_o / stall_i  root_bits_o [30:0]
//
// one request per cycle while the result is not stalled
// pipeline order: convert register, five mul/add units, then two newton steps
// each newton step is dominated by the divider, one quotient bit a stage
// reset clears only valid bits, no clearing pass
// a stalled result freezes the whole pipeline, stall_o follows it in the same cycle
`default_nettype none
`include "assert_macros.svh"
module integer_cube_root_float import icrf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [15:0] operand_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [30:0] root_bits_o
);
  logic        en;
  logic [3:0]  p;
  logic [23:0] shv;
  logic [4:0]  ec;
  logic [7:0]  fexp;
  logic [2:0]  kk;
  flt_t        x_d, x_q;
  side_t       s_d, s_q;
  logic        v_q;

  logic  v0, v1, v2, v3, v4, vn1, vn2;
  flt_t  tx, p1, s1, p2, s2;
  side_t o0, o0t, o1, o2, o3, o4, sb, n1, n2;

  assign stall_o = valid_o & stall_i;
  assign en      = ~stall_o;

  always_comb begin
    p = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (operand_i[i]) begin
        p = 4'(i);
      end
    end
    shv = {8'b0, operand_i} << (5'd23 - {1'b0, p});
    ec  = {1'b0, p} + 5'd1;
    unique case (ec)
      5'd1, 5'd4, 5'd7, 5'd10, 5'd13, 5'd16: fexp = FRAC_BIAS - 8'd2;
      5'd2, 5'd5, 5'd8, 5'd11, 5'd14:        fexp = FRAC_BIAS - 8'd1;
      default:                               fexp = FRAC_BIAS;
    endcase
    unique case (ec)
      5'd1, 5'd2, 5'd3:    kk = 3'd1;
      5'd4, 5'd5, 5'd6:    kk = 3'd2;
      5'd7, 5'd8, 5'd9:    kk = 3'd3;
      5'd10, 5'd11, 5'd12: kk = 3'd4;
      5'd13, 5'd14, 5'd15: kk = 3'd5;
      default:             kk = 3'd6;
    endcase
    x_d    = {EXP_BIAS + {4'b0, p}, shv[22:0]};
    s_d    = '0;
    s_d.zero = (operand_i == 16'd0);
    s_d.k    = kk;
    s_d.aux  = {fexp, shv[22:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q <= x_d;
      s_q <= s_d;
    end
  end

  icrf_fmul u_third (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i (v_q), .a_i(x_q), .b_i(THIRD), .side_i(s_q),
    .valid_o (v0), .res_o(tx), .side_o(o0)
  );

  always_comb begin
    o0t    = o0;
    o0t.tx = tx;
  end

  icrf_fmul u_seed_a (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i (v0), .a_i(o0.aux), .b_i(SEED_A_MAG), .side_i(o0t),
    .valid_o (v1), .res_o(p1), .side_o(o1)
  );

  icrf_fadd u_seed_b (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i (v1), .sub_i(1'b1), .a_i(SEED_B), .b_i(p1), .side_i(o1),
    .valid_o (v2), .res_o(s1), .side_o(o2)
  );

  icrf_fmul u_seed_f (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i (v2), .a_i(s1), .b_i(o2.aux), .side_i(o2),
    .valid_o (v3), .res_o(p2), .side_o(o3)
  );

  icrf_fadd u_seed_c (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i (v3), .sub_i(1'b0), .a_i(p2), .b_i(SEED_C), .side_i(o3),
    .valid_o (v4), .res_o(s2), .side_o(o4)
  );

  // scale by 2^k, exact on the exponent
  always_comb begin
    sb   = o4;
    sb.r = {s2[30:23] + {5'b0, o4.k}, s2[22:0]};
  end

  icrf_newton u_nr1 (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i (v4), .side_i(sb),
    .valid_o (vn1), .side_o(n1)
  );

  icrf_newton u_nr2 (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i (vn1), .side_i(n1),
    .valid_o (vn2), .side_o(n2)
  );

  assign valid_o     = vn2;
  assign root_bits_o = n2.zero ? 31'd0 : n2.r;

  `ICRF_ASSERT(a_root_range, valid_o |-> (root_bits_o == 31'd0 || (root_bits_o[30:23] >= 8'd127 && root_bits_o[30:23] <= 8'd132)), "root out of range")
  `ICRF_ASSERT(a_hold, (valid_o && stall_i) |=> valid_o, "stalled result dropped")
endmodule
`default_nettype wire

@@ sv/icrf_fmul.sv @@
// two stage binary32 multiplier for positive normal operands
// uses icrf_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module icrf_fmul import icrf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  flt_t  a_i,
  input  flt_t  b_i,
  input  side_t side_i,
  output logic  valid_o,
  output flt_t  res_o,
  output side_t side_o
);
  logic        v1_q, v2_q;
  logic [47:0] prod_q;
  logic [9:0]  exp_q;
  side_t       side1_q, side2_q;
  flt_t        res_q, res_d;
  logic [22:0] mant;
  logic [9:0]  e;
  logic        g, st, inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= {1'b1, a_i[22:0]} * {1'b1, b_i[22:0]};
      exp_q   <= {2'b0, a_i[30:23]} + {2'b0, b_i[30:23]} - {2'b0, EXP_BIAS};
      side1_q <= side_i;
      res_q   <= res_d;
      side2_q <= side1_q;
    end
  end

  always_comb begin
    if (prod_q[47]) begin
      mant = prod_q[46:24];
      g    = prod_q[23];
      st   = |prod_q[22:0];
      e    = exp_q + 10'd1;
    end else begin
      mant = prod_q[45:23];
      g    = prod_q[22];
      st   = |prod_q[21:0];
      e    = exp_q;
    end
    inc   = g & (st | mant[0]);
    res_d = {e[7:0], mant} + {30'b0, inc};
  end

  assign valid_o = v2_q;
  assign res_o   = res_q;
  assign side_o  = side2_q;

  `ICRF_ASSERT(a_prod_norm, v1_q |-> (prod_q[47] || prod_q[46]), "product not normalized")
endmodule
`default_nettype wire

@@ sv/icrf_fadd.sv @@
// two stage binary32 adder and subtractor for positive normal operands
// uses icrf_pkg; a subtraction is only issued where the result stays positive
`default_nettype none
module icrf_fadd import icrf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  logic  sub_i,
  input  flt_t  a_i,
  input  flt_t  b_i,
  input  side_t side_i,
  output logic  valid_o,
  output flt_t  res_o,
  output side_t side_o
);
  logic        v1_q, v2_q;
  logic [26:0] ma_q, mb_q;
  logic [7:0]  exp_q;
  logic        sub_q;
  side_t       side1_q, side2_q;
  flt_t        res_q, res_d;

  flt_t        big, sml;
  logic [7:0]  d;
  logic [53:0] ext;
  logic [26:0] al;
  logic        ast;

  logic [27:0] sum;
  logic [22:0] mant;
  logic [7:0]  e;
  logic        g, st, inc;

  always_comb begin
    if (b_i > a_i) begin
      big = b_i;
      sml = a_i;
    end else begin
      big = a_i;
      sml = b_i;
    end
    d   = big[30:23] - sml[30:23];
    ext = {1'b1, sml[22:0], 3'b000, 27'b0} >> d;
    if (d >= 8'd27) begin
      al  = 27'b0;
      ast = 1'b1;
    end else begin
      al  = ext[53:27];
      ast = |ext[26:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ma_q    <= {1'b1, big[22:0], 3'b000};
      mb_q    <= {al[26:1], al[0] | ast};
      exp_q   <= big[30:23];
      sub_q   <= sub_i;
      side1_q <= side_i;
      res_q   <= res_d;
      side2_q <= side1_q;
    end
  end

  // at most one bit of left normalization occurs on the subtraction path
  always_comb begin
    if (sub_q) begin
      sum = {1'b0, ma_q} - {1'b0, mb_q};
    end else begin
      sum = {1'b0, ma_q} + {1'b0, mb_q};
    end
    if (sum[27]) begin
      mant = sum[26:4];
      g    = sum[3];
      st   = |sum[2:0];
      e    = exp_q + 8'd1;
    end else if (sum[26]) begin
      mant = sum[25:3];
      g    = sum[2];
      st   = |sum[1:0];
      e    = exp_q;
    end else begin
      mant = sum[24:2];
      g    = sum[1];
      st   = sum[0];
      e    = exp_q - 8'd1;
    end
    inc   = g & (st | mant[0]);
    res_d = {e, mant} + {30'b0, inc};
  end

  assign valid_o = v2_q;
  assign res_o   = res_q;
  assign side_o  = side2_q;
endmodule
`default_nettype wire

@@ sv/icrf_fdiv.sv @@
// pipelined restoring binary32 divider, one quotient bit per stage
// uses icrf_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module icrf_fdiv import icrf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  flt_t  a_i,
  input  flt_t  b_i,
  input  side_t side_i,
  output logic  valid_o,
  output flt_t  res_o,
  output side_t side_o
);
  logic        vld_q  [0:DIV_STEPS];
  logic [25:0] rem_q  [0:DIV_STEPS];
  logic [23:0] den_q  [0:DIV_STEPS];
  logic [24:0] quo_q  [0:DIV_STEPS];
  logic [9:0]  exp_q  [0:DIV_STEPS];
  side_t       side_q [0:DIV_STEPS];

  logic        vo_q;
  flt_t        res_q, res_d;
  side_t       so_q;

  logic [23:0] na, nb;
  logic        lt;
  logic [25:0] den_lo, den_hi;
  logic [24:0] qf;
  logic        inc;

  assign na = {1'b1, a_i[22:0]};
  assign nb = {1'b1, b_i[22:0]};
  assign lt = na < nb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= lt ? {1'b0, na, 1'b0} : {2'b0, na};
      den_q[0]  <= nb;
      quo_q[0]  <= '0;
      exp_q[0]  <= {2'b0, a_i[30:23]} - {2'b0, b_i[30:23]} + {2'b0, EXP_BIAS}
                   - {9'b0, lt};
      side_q[0] <= side_i;
    end
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    logic        ge;
    logic [25:0] diff;

    assign ge   = rem_q[i] >= {2'b0, den_q[i]};
    assign diff = ge ? rem_q[i] - {2'b0, den_q[i]} : rem_q[i];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i+1]  <= {diff[24:0], 1'b0};
        den_q[i+1]  <= den_q[i];
        quo_q[i+1]  <= {quo_q[i][23:0], ge};
        exp_q[i+1]  <= exp_q[i];
        side_q[i+1] <= side_q[i];
      end
    end
  end

  always_comb begin
    qf    = quo_q[DIV_STEPS];
    inc   = qf[0] & ((|rem_q[DIV_STEPS]) | qf[1]);
    res_d = {exp_q[DIV_STEPS][7:0], qf[23:1]} + {30'b0, inc};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= vld_q[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
      so_q  <= side_q[DIV_STEPS];
    end
  end

  assign valid_o = vo_q;
  assign res_o   = res_q;
  assign side_o  = so_q;

  assign den_lo = {2'b0, den_q[0]};
  assign den_hi = {1'b0, den_q[0], 1'b0};

  `ICRF_ASSERT(a_div_range, vld_q[0] |-> (rem_q[0] >= den_lo && rem_q[0] < den_hi), "dividend not normalized")
endmodule
`default_nettype wire

@@ sv/icrf_newton.sv @@
// one newton step r = (2/3)r + tx/(r*r) built from multiplier, divider and adder
// uses icrf_pkg, icrf_fmul, icrf_fdiv, icrf_fadd
`default_nettype none
module icrf_newton import icrf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  side_t side_i,
  output logic  valid_o,
  output side_t side_o
);
  logic  v0, v1, v2, v3;
  flt_t  sq, q, lin, rn;
  side_t s0, s1, s1q, s2, s3;

  icrf_fmul u_sq (
    .clk_i, .rst_ni, .en_i,
    .valid_i (valid_i),
    .a_i     (side_i.r),
    .b_i     (side_i.r),
    .side_i  (side_i),
    .valid_o (v0),
    .res_o   (sq),
    .side_o  (s0)
  );

  icrf_fdiv u_div (
    .clk_i, .rst_ni, .en_i,
    .valid_i (v0),
    .a_i     (s0.tx),
    .b_i     (sq),
    .side_i  (s0),
    .valid_o (v1),
    .res_o   (q),
    .side_o  (s1)
  );

  always_comb begin
    s1q     = s1;
    s1q.aux = q;
  end

  icrf_fmul u_lin (
    .clk_i, .rst_ni, .en_i,
    .valid_i (v1),
    .a_i     (s1.r),
    .b_i     (TWO_THIRD),
    .side_i  (s1q),
    .valid_o (v2),
    .res_o   (lin),
    .side_o  (s2)
  );

  icrf_fadd u_add (
    .clk_i, .rst_ni, .en_i,
    .valid_i (v2),
    .sub_i   (1'b0),
    .a_i     (lin),
    .b_i     (s2.aux),
    .side_i  (s2),
    .valid_o (v3),
    .res_o   (rn),
    .side_o  (s3)
  );

  always_comb begin
    side_o   = s3;
    side_o.r = rn;
  end

  assign valid_o = v3;
endmodule
`default_nettype wire
